@@ hdl/ils_pkg.sv @@
// Shared types and constants for the interlocked launch sequencer.
package ils_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 2;
  localparam int unsigned DriveW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [DriveW-1:0] FULL_REVERSE = 16'sh8000;
  localparam logic signed [DriveW-1:0] DRIVE_ZERO   = 16'sh0000;

  localparam logic [LevelW-1:0] LEVEL_RELEASED = 2'd0;
  localparam logic [LevelW-1:0] LEVEL_PRESSED  = 2'd1;

  localparam logic [CfgIdxW-1:0] REG_REARM_TIME = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRE_SPAN  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOW_DRIVE = 2'd2;

  localparam logic [CfgW-1:0]        RESET_REARM_TIME  = 16'd1000;
  localparam logic [CfgW-1:0]        RESET_FIRE_SPAN   = 16'd500;
  localparam logic signed [DriveW-1:0] RESET_SLOW_DRIVE = 16'sd0;

  typedef enum logic [2:0] {
    PH_OFF    = 3'd0,
    PH_HOLD   = 3'd1,
    PH_REARM  = 3'd2,
    PH_COCKED = 3'd3,
    PH_FIRE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [TimeW-1:0]  time_now;
    logic [LevelW-1:0] fire_level;
    logic [LevelW-1:0] safety_level;
    logic              kill_a;
    logic              kill_b;
    logic              pulse_switch;
    logic              arm_ready;
  } ils_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] motor_drive;
    logic [2:0]               sequencer_state;
  } ils_out_t;

  typedef struct packed {
    logic [CfgW-1:0]          rearm_time;
    logic [CfgW-1:0]          fire_span;
    logic signed [DriveW-1:0] slow_drive;
  } ils_cfg_t;

  typedef struct packed {
    phase_t                   phase;
    logic                     press_latch;
    logic                     start_pending;
    logic [TimeW-1:0]         start_stamp;
    logic                     pulse_seen;
    logic signed [DriveW-1:0] held_drive;
  } ils_state_t;

endpackage

@@ hdl/ils_cfg.sv @@
// Configuration register file for the launch sequencer.
module ils_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ils_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ils_pkg::CfgW-1:0]   cfg_data,
  output ils_pkg::ils_cfg_t          cfg
);
  import ils_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rearm_time <= RESET_REARM_TIME;
      cfg.fire_span  <= RESET_FIRE_SPAN;
      cfg.slow_drive <= RESET_SLOW_DRIVE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_REARM_TIME: cfg.rearm_time <= cfg_data;
        REG_FIRE_SPAN:  cfg.fire_span  <= cfg_data;
        REG_SLOW_DRIVE: cfg.slow_drive <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

@@ hdl/ils_step.sv @@
// One control period of the sequencer: next state and result from current state.
module ils_step (
  input  ils_pkg::ils_state_t cur,
  input  ils_pkg::ils_in_t    item,
  input  ils_pkg::ils_cfg_t   cfg,
  output ils_pkg::ils_state_t nxt,
  output ils_pkg::ils_out_t   result
);
  import ils_pkg::*;

  logic             killed;
  logic             released;
  logic             pressed;
  logic [TimeW-1:0] stamp_eff;
  logic [TimeW-1:0] elapsed;
  logic             rearm_run;
  logic             launch_run;

  assign killed   = item.kill_a && item.kill_b;
  assign released = (item.fire_level == LEVEL_RELEASED) &&
                    (item.safety_level == LEVEL_RELEASED);
  assign pressed  = (item.fire_level == LEVEL_PRESSED) &&
                    (item.safety_level == LEVEL_PRESSED);

  // timestamp is captured on the first period of rearm or fire
  assign stamp_eff  = cur.start_pending ? item.time_now : cur.start_stamp;
  assign elapsed    = item.time_now - stamp_eff;
  assign rearm_run  = elapsed < {{(TimeW-CfgW){1'b0}}, cfg.rearm_time};
  assign launch_run = elapsed < {{(TimeW-CfgW){1'b0}}, cfg.fire_span};

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_OFF: begin
        nxt.held_drive = DRIVE_ZERO;
        if (cur.press_latch && !item.kill_a && !item.kill_b) begin
          nxt.press_latch = 1'b0;
        end
        if (killed && !nxt.press_latch) begin
          nxt.press_latch = 1'b1;
          nxt.phase       = PH_HOLD;
        end
      end
      PH_HOLD, PH_COCKED: begin
        if (killed) begin
          nxt.phase = PH_OFF;
        end
        nxt.start_pending = 1'b1;
        nxt.held_drive    = DRIVE_ZERO;
        if (cur.press_latch && released) begin
          nxt.press_latch = 1'b0;
        end
        if (pressed && !nxt.press_latch &&
            ((cur.phase == PH_HOLD) || item.arm_ready)) begin
          nxt.press_latch = 1'b1;
          nxt.phase       = (cur.phase == PH_HOLD) ? PH_REARM : PH_FIRE;
        end
      end
      PH_REARM: begin
        if (killed) begin
          nxt.phase = PH_OFF;
        end
        nxt.start_stamp   = stamp_eff;
        nxt.start_pending = 1'b0;
        nxt.held_drive    = rearm_run ? FULL_REVERSE : cfg.slow_drive;
        if (item.pulse_switch) begin
          nxt.pulse_seen = 1'b1;
        end else if (cur.pulse_seen) begin
          // falling pulse edge ends rearm
          nxt.pulse_seen = 1'b0;
          nxt.phase      = PH_COCKED;
        end
      end
      PH_FIRE: begin
        if (killed) begin
          nxt.phase = PH_OFF;
        end
        nxt.start_stamp   = stamp_eff;
        nxt.start_pending = 1'b0;
        if (launch_run) begin
          nxt.held_drive = FULL_REVERSE;
        end else begin
          nxt.phase = PH_HOLD;
        end
      end
      default: begin
        nxt.phase = PH_OFF;
      end
    endcase
  end

  assign result.motor_drive     = nxt.held_drive;
  assign result.sequencer_state = nxt.phase;

endmodule

@@ hdl/interlocked_launch_sequencer.sv @@
// Top level of the interlocked launch sequencer: input register, step logic, result register.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in       | input     | in_valid / in_stall  | in_data  (ils_in_t)
//   out      | output    | out_valid/ out_stall | out_data (ils_out_t)
//   cfg      | input     | cfg_wr_en            | cfg_index, cfg_data
//
// An accepted input transaction passes the input register, then the result
// register, on its way to out. One transaction is taken per cycle while out is
// not stalled; the state register closes its loop through the step logic.
// Reset (rst, synchronous) puts the sequencer in hold with the trigger latch set
// and the configuration registers at their defaults.
// A stall on out holds the result register and, once the input register is
// full, raises in_stall in the same cycle.
module interlocked_launch_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ils_pkg::ils_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ils_pkg::ils_out_t           out_data,
  input  logic                        cfg_wr_en,
  input  logic [ils_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ils_pkg::CfgW-1:0]    cfg_data
);
  import ils_pkg::*;

  ils_cfg_t   cfg;
  ils_state_t state;
  ils_state_t state_next;
  ils_out_t   step_out;

  // input register
  logic    s1_valid;
  ils_in_t s1_data;

  logic advance;  // result register free or being drained this cycle
  logic s1_load;

  assign advance  = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || advance;
  assign in_stall = !s1_load;

  ils_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ils_step u_step (
    .cur    (state),
    .item   (s1_data),
    .cfg    (cfg),
    .nxt    (state_next),
    .result (step_out)
  );

  // control and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
      state.phase         <= PH_HOLD;
      state.press_latch   <= 1'b1;
      state.start_pending <= 1'b1;
      state.start_stamp   <= '0;
      state.pulse_seen    <= 1'b0;
      state.held_drive    <= DRIVE_ZERO;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        // the state moves only when a transaction leaves the input register
        if (s1_valid) begin
          state <= state_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_data <= in_data;
    end
    if (advance && s1_valid) begin
      out_data <= step_out;
    end
  end

endmodule

@@ hdl/ils_checker.sv @@
// Port-level checker for the launch sequencer, bound to the top level.
module ils_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input ils_pkg::ils_out_t out_data
);
  import ils_pkg::*;

  logic       prev_valid;
  logic [2:0] prev_state;
  logic       out_take;

  assign out_take = out_valid && !out_stall;

  // phase shown by the previous result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      prev_state <= PH_HOLD;
    end else if (out_take) begin
      prev_valid <= 1'b1;
      prev_state <= out_data.sequencer_state;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_off_exit: assert property (@(posedge clk) disable iff (rst)
    out_take && prev_valid && prev_state == PH_OFF |->
      out_data.motor_drive == DRIVE_ZERO &&
      (out_data.sequencer_state == PH_OFF || out_data.sequencer_state == PH_HOLD))
    else $error("bad step out of off");

  a_idle_drive: assert property (@(posedge clk) disable iff (rst)
    out_take && prev_valid && (prev_state == PH_HOLD || prev_state == PH_COCKED) |->
      out_data.motor_drive == DRIVE_ZERO)
    else $error("motor driven after hold or cocked");

  a_fire_exit: assert property (@(posedge clk) disable iff (rst)
    out_take && prev_valid && prev_state == PH_FIRE |->
      out_data.sequencer_state == PH_FIRE || out_data.sequencer_state == PH_HOLD ||
      out_data.sequencer_state == PH_OFF)
    else $error("bad step out of fire");

  a_rearm_exit: assert property (@(posedge clk) disable iff (rst)
    out_take && prev_valid && prev_state == PH_REARM |->
      out_data.sequencer_state == PH_REARM || out_data.sequencer_state == PH_COCKED ||
      out_data.sequencer_state == PH_OFF)
    else $error("bad step out of rearm");

endmodule

bind interlocked_launch_sequencer ils_checker u_ils_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ dv/interlocked_launch_sequencer_tb.sv @@
// Self-checking testbench for the interlocked launch sequencer.
module interlocked_launch_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int StuckLimit = 1000;   // cycles with no transaction on either side
  localparam int PhaseItems = 35;     // random control periods per configuration phase
  localparam int Phases     = 9;
  localparam int HoldOffLen = 60;     // long receiver hold-off, in cycles
  localparam int DrainWait  = 4;      // covers the input and result registers plus margin

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ils_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ils_out_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_REARM_TIME;
  logic [CfgW-1:0]    cfg_data  = '0;

  interlocked_launch_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the configuration registers, reset defaults.
  logic [CfgW-1:0]          rearm_t  = RESET_REARM_TIME;
  logic [CfgW-1:0]          launch_t = RESET_FIRE_SPAN;
  logic signed [DriveW-1:0] slow_t   = RESET_SLOW_DRIVE;

  // Shadow sequencer state, reset values.
  phase_t                   seq_phase = PH_HOLD;
  logic                     trig_latch = 1'b1;    // release-before-repress latch
  logic                     stamp_due  = 1'b1;    // take a new start stamp on next timed step
  logic [TimeW-1:0]         start_tick = '0;
  logic                     pulse_hit  = 1'b0;
  logic signed [DriveW-1:0] motor_cmd  = DRIVE_ZERO;

  ils_in_t  pending_periods[$];   // control periods waiting to be offered
  ils_out_t expected_cmds[$];     // predicted results, oldest first

  int   mismatches = 0;
  int   added      = 0;
  logic quiet      = 1'b0;        // no idling on either side while set
  int   hold_off_req  = 0;        // bumped by the stimulus to ask for a long stall
  int   hold_off_seen = 0;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   stuck_cycles = 0;

  logic [TimeW-1:0] tick = '0;    // running timestamp for generated periods
  int               tick_step = 4;

  // One control period through the shadow sequencer; returns the expected result.
  function automatic ils_out_t predict_period(ils_in_t x);
    logic             killed;
    logic             released;
    logic             pressed;
    logic             allowed;
    logic [TimeW-1:0] el;
    phase_t           nxt;
    ils_out_t         r;
    killed   = x.kill_a & x.kill_b;
    released = (x.fire_level == LEVEL_RELEASED) && (x.safety_level == LEVEL_RELEASED);
    pressed  = (x.fire_level == LEVEL_PRESSED) && (x.safety_level == LEVEL_PRESSED);
    case (seq_phase)
      PH_OFF: begin
        motor_cmd = DRIVE_ZERO;
        if (trig_latch && !x.kill_a && !x.kill_b) trig_latch = 1'b0;
        if (killed && !trig_latch) begin
          trig_latch = 1'b1;
          seq_phase  = PH_HOLD;
        end
      end
      PH_HOLD, PH_COCKED: begin
        nxt     = (seq_phase == PH_HOLD) ? PH_REARM : PH_FIRE;
        allowed = (seq_phase == PH_HOLD) ? 1'b1 : x.arm_ready;
        // kill first; a trigger transition below wins over it
        if (killed) seq_phase = PH_OFF;
        stamp_due = 1'b1;
        motor_cmd = DRIVE_ZERO;
        if (trig_latch && released) trig_latch = 1'b0;
        if (pressed && !trig_latch && allowed) begin
          trig_latch = 1'b1;
          seq_phase  = nxt;
        end
      end
      PH_REARM: begin
        if (killed) seq_phase = PH_OFF;
        if (stamp_due) begin
          start_tick = x.time_now;
          stamp_due  = 1'b0;
        end
        el = x.time_now - start_tick;   // modulo 2^32
        motor_cmd = (el < {16'd0, rearm_t}) ? FULL_REVERSE : slow_t;
        if (x.pulse_switch) pulse_hit = 1'b1;
        // falling cam pulse edge ends rearm, flag cleared on the way out
        if (!x.pulse_switch && pulse_hit) begin
          pulse_hit = 1'b0;
          seq_phase = PH_COCKED;
        end
      end
      PH_FIRE: begin
        if (killed) seq_phase = PH_OFF;
        if (stamp_due) begin
          start_tick = x.time_now;
          stamp_due  = 1'b0;
        end
        el = x.time_now - start_tick;
        if (el < {16'd0, launch_t}) motor_cmd = FULL_REVERSE;
        else seq_phase = PH_HOLD;     // motor command left as it was
      end
      default: seq_phase = PH_OFF;
    endcase
    r.motor_drive     = motor_cmd;
    r.sequencer_state = seq_phase;
    return r;
  endfunction

  // Driver: offers queued periods, predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_cmds.push_back(predict_period(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_periods.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);   // idle burst before the next period
          in_valid <= 1'b0;
        end else if (pending_periods.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_periods.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and drives stall.
  always @(posedge clk) begin
    ils_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual drive %0d state %0d",
                 $time, out_data.motor_drive, out_data.sequencer_state);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        if (out_data.motor_drive !== want.motor_drive) begin
          $display("%0t: motor_drive expected %0d actual %0d",
                   $time, want.motor_drive, out_data.motor_drive);
          mismatches++;
        end
        if (out_data.sequencer_state !== want.sequencer_state) begin
          $display("%0t: sequencer_state expected %0d actual %0d",
                   $time, want.sequencer_state, out_data.sequencer_state);
          mismatches++;
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_seen != hold_off_req) begin
      // long hold-off so the block backs up and stalls its input
      hold_off_seen = hold_off_req;
      stall_left = HoldOffLen - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no transaction anywhere.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Queue one control period; the timestamp advances by a random step.
  task automatic add(input logic [1:0] f, input logic [1:0] s, input logic ka,
                     input logic kb, input logic pu, input logic arm);
    ils_in_t x;
    tick = tick + $urandom_range(0, tick_step);
    x.time_now     = tick;
    x.fire_level   = f;
    x.safety_level = s;
    x.kill_a       = ka;
    x.kill_b       = kb;
    x.pulse_switch = pu;
    x.arm_ready    = arm;
    pending_periods.push_back(x);
    added++;
  endtask

  // Full hold -> rearm -> cocked -> fire -> hold pass with random filler.
  task automatic launch_cycle();
    int n;
    repeat ($urandom_range(1, 2))
      add(LEVEL_RELEASED, LEVEL_RELEASED, $urandom_range(0, 1), 1'b0, 1'b0, $urandom_range(0, 1));
    repeat ($urandom_range(1, 2))
      add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, $urandom_range(0, 1), 1'b0, $urandom_range(0, 1));
    // rearm: low pulse, then a pulse, then the falling edge
    repeat ($urandom_range(0, 6))
      add($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1), 1'b0, 1'b0,
          $urandom_range(0, 1));
    repeat ($urandom_range(1, 3))
      add($urandom_range(0, 3), $urandom_range(0, 3), 1'b0, $urandom_range(0, 1), 1'b1,
          $urandom_range(0, 1));
    add($urandom_range(0, 3), $urandom_range(0, 3), 1'b0, 1'b0, 1'b0, $urandom_range(0, 1));
    // cocked: release, maybe a press with the arm interlock open, then fire
    repeat ($urandom_range(1, 2))
      add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, $urandom_range(0, 1), $urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0)
      add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, $urandom_range(0, 1), 1'b0);
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, $urandom_range(0, 1), 1'b1);
    // fire until launch time runs out
    n = launch_t / (tick_step / 2 + 1) + $urandom_range(1, 3);
    if (n > 12) n = 12;
    repeat (n)
      add(LEVEL_RELEASED, LEVEL_RELEASED, $urandom_range(0, 1), 1'b0, $urandom_range(0, 1),
          $urandom_range(0, 1));
  endtask

  // Both kills to off, release them, both again back to hold.
  task automatic kill_cycle();
    repeat ($urandom_range(1, 2))
      add($urandom_range(0, 3), $urandom_range(0, 3), 1'b1, 1'b1, 1'b0, $urandom_range(0, 1));
    repeat ($urandom_range(1, 2))
      add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, $urandom_range(0, 1), 1'b0, 1'b0);
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0);
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b1, 1'b1, 1'b0, 1'b0);
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) tick = $urandom;
      add($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
          $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  // Three back-to-back register writes; shadow copy follows.
  task automatic load_registers(input logic [CfgW-1:0] rt, input logic [CfgW-1:0] lt,
                                input logic signed [DriveW-1:0] sd);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_REARM_TIME;
    cfg_data  <= rt;
    @(posedge clk);
    cfg_index <= REG_FIRE_SPAN;
    cfg_data  <= lt;
    @(posedge clk);
    cfg_index <= REG_SLOW_DRIVE;
    cfg_data  <= sd;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rearm_t  = rt;
    launch_t = lt;
    slow_t   = sd;
  endtask

  // Wait until everything offered has come back, then let the pipe go quiet.
  task automatic settle();
    while (pending_periods.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(negedge clk);
    @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  initial begin
    int start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration. Timestamp starts near wrap.
    tick = 32'hFFFF_FFF0;
    tick_step = 4;
    add(2'd3, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0);                        // level three: not released
    add(LEVEL_RELEASED, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0);
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0);    // latch clears
    add(LEVEL_PRESSED, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0);
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b1, 1'b0, 1'b0, 1'b0);      // single kill ignored, rearm
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, 1'b1, 1'b0);      // stamp taken across wrap
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b1, 1'b1, 1'b0, 1'b0);    // kill overridden by cocked
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, 1'b0, 1'b1);      // latch still set
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b1);
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, 1'b0, 1'b0);      // arm not ready
    add(2'd2, LEVEL_PRESSED, 1'b0, 1'b0, 1'b0, 1'b1);
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, 1'b1, 1'b1);      // fire
    tick = tick + 400;
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, 1'b0, 1'b1);      // still inside launch time
    tick = tick + 200;
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b1, 1'b1, 1'b0, 1'b0);    // kill ends fire inside launch time
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b1, 1'b1, 1'b0, 1'b0);    // stays off, latch set
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b1, 1'b1, 1'b0, 1'b0);    // latch held
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b1, 1'b0, 1'b0);
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0);    // latch clears
    add(2'd3, 2'd3, 1'b1, 1'b1, 1'b0, 1'b0);                        // off to hold
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0);
    add(LEVEL_PRESSED, LEVEL_PRESSED, 1'b0, 1'b0, 1'b0, 1'b0);      // rearm
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0);    // stamp, full reverse
    tick = tick + 1000;
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b0);    // slow drive
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b1, 1'b1, 1'b1, 1'b0);    // kill in rearm
    add(LEVEL_RELEASED, LEVEL_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0);    // off drives zero
    settle();

    // Random phases, one register setting each.
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin
          tick_step = 4;
          load_registers(16'd0, 16'd0, 16'sh7FFF);
        end
        1: begin
          tick_step = 20000;   // big steps so the longest times still run out
          load_registers(16'hFFFF, 16'hFFFF, FULL_REVERSE);
        end
        default: begin
          tick_step = 8;
          load_registers($urandom_range(0, 40), $urandom_range(0, 40), $urandom);
        end
      endcase
      quiet = (p == 4) || (p == Phases - 1);
      if (p == 2) hold_off_req++;
      start = added;
      while (added - start < PhaseItems) begin
        case ($urandom_range(0, 9))
          7:       kill_cycle();
          8, 9:    noise_burst();
          default: launch_cycle();
        endcase
      end
      settle();
    end

    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ils_pkg.sv
hdl/ils_cfg.sv
hdl/ils_step.sv
hdl/interlocked_launch_sequencer.sv
hdl/ils_checker.sv
dv/interlocked_launch_sequencer_tb.sv
